[rtl/pedal_plausibility_torque_ctrl_macros.svh]
// Assertion macros for the pedal plausibility block checker.
// No dependencies; included by the checker file only.
`ifndef PEDAL_PLAUSIBILITY_TORQUE_CTRL_MACROS_SVH
`define PEDAL_PLAUSIBILITY_TORQUE_CTRL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pedal plausibility check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pedal plausibility check failed");

`endif

[rtl/ppt_pkg.sv]
// Shared types and constants for the pedal plausibility torque controller.
// No dependencies; used by the divider lane, the top level and the checker.
package ppt_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int TRAVEL_W  = 13;
	localparam int Q_FRAC    = 12;
	localparam int LIMIT_W   = 13;
	localparam int COUNT_W   = 10;
	localparam int TORQUE_W  = 15;
	localparam int WAIT_W    = 4;
	localparam int FAULT_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 15;
	localparam int STEP_W    = 4;
	localparam int PROD_W    = TORQUE_W + TRAVEL_W;

	localparam logic [STEP_W-1:0]   STEP_LAST      = STEP_W'(TRAVEL_W - 1);
	localparam logic [SAMPLE_W-1:0] RANGE_TOP      = SAMPLE_W'((9 << SAMPLE_W) / 10);
	localparam logic [WAIT_W-1:0]   DEBOUNCE_TICKS = WAIT_W'(10);
	localparam logic [COUNT_W-1:0]  SOUNDER_TICKS  = COUNT_W'(1000);
	localparam logic [COUNT_W-1:0]  COUNT_MAX      = {COUNT_W{1'b1}};

	localparam logic [SAMPLE_W-1:0] FIRST_LOW_RST   = SAMPLE_W'(614);
	localparam logic [SAMPLE_W-1:0] FIRST_HIGH_RST  = SAMPLE_W'(2990);
	localparam logic [SAMPLE_W-1:0] SECOND_LOW_RST  = SAMPLE_W'(573);
	localparam logic [SAMPLE_W-1:0] SECOND_HIGH_RST = SAMPLE_W'(2335);
	localparam logic [LIMIT_W-1:0]  DIFF_LIMIT_RST  = LIMIT_W'(410);
	localparam logic [COUNT_W-1:0]  PERSIST_RST     = COUNT_W'(100);
	localparam logic [TORQUE_W-1:0] MAX_TORQUE_RST  = TORQUE_W'(30000);
	localparam logic [TORQUE_W-1:0] MAX_SPEED_RST   = TORQUE_W'(7500);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_LOW     = 3'd0,
		REG_FIRST_HIGH    = 3'd1,
		REG_SECOND_LOW    = 3'd2,
		REG_SECOND_HIGH   = 3'd3,
		REG_DIFF_LIMIT    = 3'd4,
		REG_PERSIST_TICKS = 3'd5,
		REG_MAX_TORQUE    = 3'd6,
		REG_MAX_SPEED     = 3'd7
	} cfg_reg_t;

	localparam logic [FAULT_W-1:0] FAULT_NONE    = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_PERSIST = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_RANGE   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_AVG,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
	} lane_ctl_t;

	typedef struct packed {
		lane_ctl_t lane;
		logic      avg_load;
		logic      mul_step;
		logic      commit;
		logic      busy;
	} ctl_t;

endpackage

[rtl/ppt_div_lane.sv]
// One restoring divider lane: clamps a sensor sample to its span and produces
// Q12 travel one quotient bit per cycle. Depends on ppt_pkg.
module ppt_div_lane (
	input  logic                             clk,
	input  ppt_pkg::lane_ctl_t               ctl,
	input  logic [ppt_pkg::SAMPLE_W-1:0]     sample,
	input  logic [ppt_pkg::SAMPLE_W-1:0]     low,
	input  logic [ppt_pkg::SAMPLE_W-1:0]     high,
	output logic [ppt_pkg::TRAVEL_W-1:0]     quotient
);

	logic [ppt_pkg::SAMPLE_W-1:0] clamped;
	logic [ppt_pkg::SAMPLE_W-1:0] offset;
	logic [ppt_pkg::SAMPLE_W-1:0] span;
	logic                         empty;
	logic [ppt_pkg::SAMPLE_W:0]   trial;
	logic [ppt_pkg::SAMPLE_W:0]   trial_sub;
	logic                         fits;

	logic [ppt_pkg::SAMPLE_W-1:0] rem_q;
	logic [ppt_pkg::SAMPLE_W-1:0] div_q;
	logic [ppt_pkg::TRAVEL_W-1:0] num_q;
	logic [ppt_pkg::TRAVEL_W-1:0] quo_q;
	logic                         empty_q;

	always_comb begin
		empty = (high <= low);
		if (sample < low) begin
			clamped = low;
		end else if (sample > high) begin
			clamped = high;
		end else begin
			clamped = sample;
		end
		offset    = clamped - low;
		span      = high - low;
		trial     = {rem_q, num_q[ppt_pkg::TRAVEL_W-1]};
		fits      = (trial >= {1'b0, div_q});
		trial_sub = trial - {1'b0, div_q};
	end

	// The dividend is offset * 4096; its top bits are below the span, so seed
	// the remainder with offset >> 1 and shift in the last 13 dividend bits.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q   <= {1'b0, offset[ppt_pkg::SAMPLE_W-1:1]};
			num_q   <= {offset[0], {(ppt_pkg::TRAVEL_W-1){1'b0}}};
			div_q   <= span;
			empty_q <= empty;
			quo_q   <= '0;
		end else if (ctl.step) begin
			rem_q <= fits ? trial_sub[ppt_pkg::SAMPLE_W-1:0] : trial[ppt_pkg::SAMPLE_W-1:0];
			num_q <= {num_q[ppt_pkg::TRAVEL_W-2:0], 1'b0};
			quo_q <= {quo_q[ppt_pkg::TRAVEL_W-2:0], fits};
		end
	end

	assign quotient = empty_q ? '0 : quo_q;

endmodule

[rtl/pedal_plausibility_torque_ctrl.sv]
// Channel   | handshake                   | payload
// input     | in_valid / in_stall (out)   | first_sample, second_sample, switch_level,
//           |                             | status_valid, status_ready
// result    | out_valid / out_stall (in)  | motor_enabled, power_ready, torque_demand,
//           |                             | speed_limit, avg_travel, sounder_on, fault
// config    | cfg_valid / cfg_ready (out) | cfg_index, cfg_data
// An item passes from accept through the two bit-serial divider lanes, an
// averaging step, the bit-serial torque multiplier and a commit step that
// updates state and loads the result register; in_stall then drops back in
// idle, where the next beat is accepted.
// The commit waits while the result register holds a beat that is stalled.
// Reset clears all tick state and loads the register defaults; cfg_ready is always high.
// Depends on ppt_pkg and ppt_div_lane.
module pedal_plausibility_torque_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ppt_pkg::SAMPLE_W-1:0]      first_sample,
	input  logic [ppt_pkg::SAMPLE_W-1:0]      second_sample,
	input  logic                              switch_level,
	input  logic                              status_valid,
	input  logic                              status_ready,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              motor_enabled,
	output logic                              power_ready,
	output logic [ppt_pkg::TORQUE_W-1:0]      torque_demand,
	output logic [ppt_pkg::TORQUE_W-1:0]      speed_limit,
	output logic [ppt_pkg::TRAVEL_W-1:0]      avg_travel,
	output logic                              sounder_on,
	output logic [ppt_pkg::FAULT_W-1:0]       fault,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppt_pkg::CFG_DAT_W-1:0]     cfg_data
);

	// Configuration registers
	logic [ppt_pkg::SAMPLE_W-1:0] first_low_q, first_high_q, second_low_q, second_high_q;
	logic [ppt_pkg::LIMIT_W-1:0]  diff_limit_q;
	logic [ppt_pkg::COUNT_W-1:0]  persist_ticks_q;
	logic [ppt_pkg::TORQUE_W-1:0] max_torque_q, max_speed_q;

	// Tick state
	logic                         ready_latch_q, enabled_q, prev_switch_q;
	logic [ppt_pkg::WAIT_W-1:0]   rise_wait_q, fall_wait_q;
	logic                         sounder_used_q;
	logic [ppt_pkg::COUNT_W-1:0]  sounder_count_q, persist_count_q;
	logic                         persist_running_q;

	// Sequencer and datapath
	ppt_pkg::state_t              state_q, state_d;
	ppt_pkg::ctl_t                ctl;
	logic [ppt_pkg::STEP_W-1:0]   step_q;
	logic                         step_last;
	logic                         out_free;

	logic [ppt_pkg::SAMPLE_W-1:0] s1_q, s2_q;
	logic                         level_q, stat_valid_q, stat_ready_q;
	logic [ppt_pkg::TRAVEL_W-1:0] t1, t2;
	logic [ppt_pkg::TRAVEL_W:0]   travel_sum;
	logic [ppt_pkg::TRAVEL_W-1:0] avg_q, avg_sr_q;
	logic [ppt_pkg::PROD_W-1:0]   acc_q;
	logic [ppt_pkg::TORQUE_W:0]   acc_sum;

	// Commit values
	logic                         ready_latch_d, enabled_d, sounder_used_d, persist_running_d;
	logic [ppt_pkg::WAIT_W-1:0]   rise_wait_d, fall_wait_d;
	logic [ppt_pkg::COUNT_W-1:0]  sounder_count_d, persist_count_d;
	logic [ppt_pkg::FAULT_W-1:0]  fault_d;
	logic [ppt_pkg::TRAVEL_W-1:0] diff;
	logic                         range_bad;

	// Result register
	logic                         out_valid_q, motor_enabled_q, power_ready_q, sounder_on_q;
	logic [ppt_pkg::TORQUE_W-1:0] torque_q, speed_q;
	logic [ppt_pkg::TRAVEL_W-1:0] travel_q;
	logic [ppt_pkg::FAULT_W-1:0]  fault_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign step_last = (step_q == ppt_pkg::STEP_LAST);

	ppt_div_lane u_lane_first (
		.clk      (clk),
		.ctl      (ctl.lane),
		.sample   (first_sample),
		.low      (first_low_q),
		.high     (first_high_q),
		.quotient (t1)
	);

	ppt_div_lane u_lane_second (
		.clk      (clk),
		.ctl      (ctl.lane),
		.sample   (second_sample),
		.low      (second_low_q),
		.high     (second_high_q),
		.quotient (t2)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ppt_pkg::ST_IDLE: if (in_valid) state_d = ppt_pkg::ST_DIV;
			ppt_pkg::ST_DIV:  if (step_last) state_d = ppt_pkg::ST_AVG;
			ppt_pkg::ST_AVG:  state_d = ppt_pkg::ST_MUL;
			ppt_pkg::ST_MUL:  if (step_last) state_d = ppt_pkg::ST_DONE;
			ppt_pkg::ST_DONE: if (out_free) state_d = ppt_pkg::ST_IDLE;
			default:          state_d = ppt_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			ppt_pkg::ST_IDLE: ctl.lane.start = in_valid;
			ppt_pkg::ST_DIV: begin
				ctl.lane.step = 1'b1;
				ctl.busy      = 1'b1;
			end
			ppt_pkg::ST_AVG: begin
				ctl.avg_load = 1'b1;
				ctl.busy     = 1'b1;
			end
			ppt_pkg::ST_MUL: begin
				ctl.mul_step = 1'b1;
				ctl.busy     = 1'b1;
			end
			ppt_pkg::ST_DONE: begin
				ctl.commit = out_free;
				ctl.busy   = 1'b1;
			end
			default: ctl.busy = 1'b1;
		endcase
	end

	assign in_stall = ctl.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppt_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if ((ctl.lane.step || ctl.mul_step) && !step_last) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// Item capture, average and shift-add torque multiplier
	assign travel_sum = {1'b0, t1} + {1'b0, t2};
	assign acc_sum    = {1'b0, acc_q[ppt_pkg::PROD_W-1:ppt_pkg::TRAVEL_W]}
		+ (avg_sr_q[0] ? {1'b0, max_torque_q} : '0);

	always_ff @(posedge clk) begin
		if (ctl.lane.start) begin
			s1_q         <= first_sample;
			s2_q         <= second_sample;
			level_q      <= switch_level;
			stat_valid_q <= status_valid;
			stat_ready_q <= status_ready;
		end
		if (ctl.avg_load) begin
			avg_q    <= travel_sum[ppt_pkg::TRAVEL_W:1];
			avg_sr_q <= travel_sum[ppt_pkg::TRAVEL_W:1];
			acc_q    <= '0;
		end else if (ctl.mul_step) begin
			// Advance one multiplier bit, LSB first
			avg_sr_q <= {1'b0, avg_sr_q[ppt_pkg::TRAVEL_W-1:1]};
			acc_q    <= {acc_sum, acc_q[ppt_pkg::TRAVEL_W-1:1]};
		end
	end

	// Tick state update, in the order the tick is defined
	always_comb begin
		diff = (t1 >= t2) ? (t1 - t2) : (t2 - t1);
		range_bad = (s1_q == '0) || (s2_q == '0)
			|| (s1_q >= ppt_pkg::RANGE_TOP) || (s2_q >= ppt_pkg::RANGE_TOP);

		ready_latch_d     = stat_valid_q ? stat_ready_q : ready_latch_q;
		sounder_count_d   = (sounder_count_q != '0) ? sounder_count_q - 1'b1 : sounder_count_q;
		persist_count_d   = (persist_running_q && persist_count_q != ppt_pkg::COUNT_MAX)
			? persist_count_q + 1'b1 : persist_count_q;
		persist_running_d = persist_running_q;
		enabled_d         = enabled_q;
		sounder_used_d    = sounder_used_q;
		rise_wait_d       = rise_wait_q;
		fall_wait_d       = fall_wait_q;
		fault_d           = ppt_pkg::FAULT_NONE;

		if (enabled_q) begin
			if (diff > diff_limit_q) begin
				if (persist_running_q && (persist_count_d > persist_ticks_q
					|| persist_count_d == ppt_pkg::COUNT_MAX)) begin
					fault_d   = ppt_pkg::FAULT_PERSIST;
					enabled_d = 1'b0;
				end else if (!persist_running_q) begin
					persist_running_d = 1'b1;
					persist_count_d   = '0;
				end
			end else begin
				persist_running_d = 1'b0;
				persist_count_d   = '0;
			end
			if (range_bad) begin
				fault_d   = ppt_pkg::FAULT_RANGE;
				enabled_d = 1'b0;
			end
		end

		if (rise_wait_q != '0) begin
			rise_wait_d = rise_wait_q - 1'b1;
			if (rise_wait_d == '0 && level_q && ready_latch_d) begin
				enabled_d = 1'b1;
				if (!sounder_used_q) begin
					sounder_used_d  = 1'b1;
					sounder_count_d = ppt_pkg::SOUNDER_TICKS;
				end
			end
		end
		if (fall_wait_q != '0) begin
			fall_wait_d = fall_wait_q - 1'b1;
			if (fall_wait_d == '0 && !level_q) enabled_d = 1'b0;
		end

		// Arm a debounce check on a new edge unless one of that kind is pending
		if (level_q && !prev_switch_q && rise_wait_d == '0) begin
			rise_wait_d = ppt_pkg::DEBOUNCE_TICKS;
		end
		if (!level_q && prev_switch_q && fall_wait_d == '0) begin
			fall_wait_d = ppt_pkg::DEBOUNCE_TICKS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_latch_q     <= 1'b0;
			enabled_q         <= 1'b0;
			prev_switch_q     <= 1'b0;
			rise_wait_q       <= '0;
			fall_wait_q       <= '0;
			sounder_used_q    <= 1'b0;
			sounder_count_q   <= '0;
			persist_count_q   <= '0;
			persist_running_q <= 1'b0;
		end else if (ctl.commit) begin
			ready_latch_q     <= ready_latch_d;
			enabled_q         <= enabled_d;
			prev_switch_q     <= level_q;
			rise_wait_q       <= rise_wait_d;
			fall_wait_q       <= fall_wait_d;
			sounder_used_q    <= sounder_used_d;
			sounder_count_q   <= sounder_count_d;
			persist_count_q   <= persist_count_d;
			persist_running_q <= persist_running_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_low_q     <= ppt_pkg::FIRST_LOW_RST;
			first_high_q    <= ppt_pkg::FIRST_HIGH_RST;
			second_low_q    <= ppt_pkg::SECOND_LOW_RST;
			second_high_q   <= ppt_pkg::SECOND_HIGH_RST;
			diff_limit_q    <= ppt_pkg::DIFF_LIMIT_RST;
			persist_ticks_q <= ppt_pkg::PERSIST_RST;
			max_torque_q    <= ppt_pkg::MAX_TORQUE_RST;
			max_speed_q     <= ppt_pkg::MAX_SPEED_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (ppt_pkg::cfg_reg_t'(cfg_index))
				ppt_pkg::REG_FIRST_LOW:     first_low_q     <= cfg_data[ppt_pkg::SAMPLE_W-1:0];
				ppt_pkg::REG_FIRST_HIGH:    first_high_q    <= cfg_data[ppt_pkg::SAMPLE_W-1:0];
				ppt_pkg::REG_SECOND_LOW:    second_low_q    <= cfg_data[ppt_pkg::SAMPLE_W-1:0];
				ppt_pkg::REG_SECOND_HIGH:   second_high_q   <= cfg_data[ppt_pkg::SAMPLE_W-1:0];
				ppt_pkg::REG_DIFF_LIMIT:    diff_limit_q    <= cfg_data[ppt_pkg::LIMIT_W-1:0];
				ppt_pkg::REG_PERSIST_TICKS: persist_ticks_q <= cfg_data[ppt_pkg::COUNT_W-1:0];
				ppt_pkg::REG_MAX_TORQUE:    max_torque_q    <= cfg_data[ppt_pkg::TORQUE_W-1:0];
				ppt_pkg::REG_MAX_SPEED:     max_speed_q     <= cfg_data[ppt_pkg::TORQUE_W-1:0];
				default: ;
			endcase
		end
	end

	// Result register: hold a stalled beat, load on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			motor_enabled_q <= enabled_d;
			power_ready_q   <= enabled_q;
			torque_q        <= enabled_q
				? acc_q[ppt_pkg::Q_FRAC+ppt_pkg::TORQUE_W-1:ppt_pkg::Q_FRAC] : '0;
			speed_q         <= max_speed_q;
			travel_q        <= enabled_q ? avg_q : '0;
			sounder_on_q    <= (sounder_count_d != '0);
			fault_q         <= fault_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_enabled = motor_enabled_q;
	assign power_ready   = power_ready_q;
	assign torque_demand = torque_q;
	assign speed_limit   = speed_q;
	assign avg_travel    = travel_q;
	assign sounder_on    = sounder_on_q;
	assign fault         = fault_q;

endmodule

[rtl/ppt_checker.sv]
// Port-level checker for the pedal plausibility torque controller, bound to the top.
// Depends on ppt_pkg and pedal_plausibility_torque_ctrl_macros.svh.
`include "pedal_plausibility_torque_ctrl_macros.svh"

module ppt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              power_ready,
	input logic [ppt_pkg::TORQUE_W-1:0]      torque_demand,
	input logic [ppt_pkg::TRAVEL_W-1:0]      avg_travel,
	input logic [ppt_pkg::FAULT_W-1:0]       fault
);

	// A tick with the motor off at its start reports no demand and no fault
	`PPT_ASSERT_NOW(a_off_quiet, clk, arst_n, out_valid && !power_ready,
		torque_demand == '0 && avg_travel == '0 && fault == ppt_pkg::FAULT_NONE)

	// Averaged travel never exceeds full pedal
	`PPT_ASSERT_NOW(a_travel_max, clk, arst_n, out_valid,
		avg_travel <= ppt_pkg::TRAVEL_W'(1 << ppt_pkg::Q_FRAC))

	// One item at a time: stall right after an accepted beat
	`PPT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// A stalled result beat holds
	`PPT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(torque_demand) && $stable(fault))

endmodule

bind pedal_plausibility_torque_ctrl ppt_checker u_ppt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.power_ready   (power_ready),
	.torque_demand (torque_demand),
	.avg_travel    (avg_travel),
	.fault         (fault)
);
